// ===== rtl/cdfb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdfb_pkg
// Shared types and constants for the chained display frame builder.
// ----------------------------------------------------------------------------
package cdfb_pkg;

  // Request kinds.
  localparam logic [1:0] REQ_TARGETED  = 2'd0;
  localparam logic [1:0] REQ_BROADCAST = 2'd1;
  localparam logic [1:0] REQ_DECIMAL   = 2'd2;
  localparam logic [1:0] REQ_NONE      = 2'd3;

  // Code-B characters used by decimal writes.
  localparam logic [7:0] CODE_DASH  = 8'h0A;
  localparam logic [7:0] CODE_BLANK = 8'h0F;

  // Largest value that still fits on four digits.
  localparam logic [15:0] VALUE_MAX = 16'd9999;

  localparam int NUM_MODULES_DEFAULT = 4;

  // Depth of the frame descriptor queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // One frame to be sent: the word for the target slot (or every slot).
  typedef struct packed {
    logic       all;
    logic [3:0] target;
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } desc_t;

endpackage : cdfb_pkg
`default_nettype wire

// ===== rtl/chained_display_frame_builder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chained_display_frame_builder_top
// Word stream builder for a daisy chain of seven-segment display drivers.
// ----------------------------------------------------------------------------
// Each request transaction becomes a stream of result transactions, one word
// per cycle, each word a register address and a data byte for one slot of the
// chain. A targeted write or a broadcast yields one frame of NUM_MODULES words;
// a decimal write yields four frames, 4*NUM_MODULES words, for digits 4 down
// to 1. Frames start at module NUM_MODULES and end at module 1, where
// end_of_frame is set; last marks the final word of a request. The sustained
// rate is one word per cycle, set by the back part, while the receiver keeps
// out_ready high. A reserved request type is taken and produces nothing.
// Requests are taken while earlier words are still going out: the front part
// converts one digit per cycle, while the queue has room, into frame
// descriptors that wait in a four-entry queue. A decimal request keeps the
// input closed while its first three digits are formed; the cycle that forms
// its fourth digit already admits the next request, unless the queue is full.
// ----------------------------------------------------------------------------
module chained_display_frame_builder_top #(
  parameter int NUM_MODULES = cdfb_pkg::NUM_MODULES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [3:0]  module_req,
  input  wire logic [3:0]  reg_addr,
  input  wire logic [7:0]  reg_data,
  input  wire logic [15:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       word_addr,
  output logic [7:0]       word_data,
  output logic             end_of_frame,
  output logic             last
);
  import cdfb_pkg::*;

  // Descriptor traffic between the front part, the queue and the back part.
  logic  push;
  desc_t push_data;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  desc_t q_data;

  // The front part classifies each request and emits frame descriptors.
  cdfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .module_req (module_req),
    .reg_addr   (reg_addr),
    .reg_data   (reg_data),
    .value      (value),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  // The queue lets the front run ahead while the back is stalled downstream.
  cdfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // The back part walks the slots of each frame into the output register.
  cdfb_back #(
    .NUM_MODULES (NUM_MODULES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word_addr    (word_addr),
    .word_data    (word_data),
    .end_of_frame (end_of_frame),
    .last         (last)
  );

`ifndef SYNTH
  // The final word of a request always closes a frame.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!last || end_of_frame))
    else $error("last word is not on the module-1 slot");

  // A decimal request keeps the input closed while its first three digits are formed.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (req_type == REQ_DECIMAL)) |=> !in_ready)
    else $error("input reopened during a decimal conversion");

  // The back part never pulls from an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("descriptor popped from an empty queue");
`endif

endmodule : chained_display_frame_builder_top
`default_nettype wire

// ===== rtl/cdfb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdfb_front
// Accepts requests and turns each into one or four frame descriptors, or none.
// ----------------------------------------------------------------------------
module cdfb_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       req_type,
  input  wire logic [3:0]       module_req,
  input  wire logic [3:0]       reg_addr,
  input  wire logic [7:0]       reg_data,
  input  wire logic [15:0]      value,
  input  wire logic             q_full,
  output logic                  push,
  output cdfb_pkg::desc_t       push_data
);
  import cdfb_pkg::*;

  localparam int REM_W = 14;

  logic             busy;
  logic [1:0]       kind;
  logic [3:0]       target;
  logic [3:0]       addr;
  logic [7:0]       data;
  logic             dash;
  logic [REM_W-1:0] rem;
  logic [1:0]       idx;
  logic             seen;

  logic [REM_W-1:0] pow;
  logic [REM_W-1:0] thr;
  logic [3:0]       digit;
  logic [7:0]       code;
  logic             accept;
  logic             done;

  // One decimal digit per cycle while the queue has room: compare the remainder
  // against the nine multiples of the current power of ten.
  always_comb begin
    unique case (idx)
      2'd0:    pow = REM_W'(1000);
      2'd1:    pow = REM_W'(100);
      2'd2:    pow = REM_W'(10);
      default: pow = REM_W'(1);
    endcase
    digit = 4'd0;
    thr   = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= REM_W'(k) * pow) begin
        digit = 4'(k);
        thr   = REM_W'(k) * pow;
      end
    end
    if (dash) begin
      code = CODE_DASH;
    end else if (!seen && (digit == 4'd0) && (idx != 2'd3)) begin
      code = CODE_BLANK;
    end else begin
      code = {4'd0, digit};
    end
  end

  always_comb begin
    push_data.target = target;
    unique case (kind)
      REQ_TARGETED: begin
        push_data.all  = 1'b0;
        push_data.addr = addr;
        push_data.data = data;
        push_data.last = 1'b1;
      end
      REQ_BROADCAST: begin
        push_data.all  = 1'b1;
        push_data.addr = addr;
        push_data.data = data;
        push_data.last = 1'b1;
      end
      REQ_DECIMAL: begin
        push_data.all  = 1'b0;
        push_data.addr = 4'd4 - {2'd0, idx};
        push_data.data = code;
        push_data.last = (idx == 2'd3);
      end
      default: begin
        push_data.all  = 1'b0;
        push_data.addr = 4'd0;
        push_data.data = 8'd0;
        push_data.last = 1'b1;
      end
    endcase
  end

  assign push     = busy && !q_full;
  assign done     = push && push_data.last;
  assign in_ready = !busy || done;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= (req_type != REQ_NONE);
    end else if (done) begin
      busy <= 1'b0;
    end

    if (accept) begin
      kind   <= req_type;
      target <= module_req;
      addr   <= reg_addr;
      data   <= reg_data;
      dash   <= (value > VALUE_MAX);
      rem    <= value[REM_W-1:0];
      idx    <= 2'd0;
      seen   <= 1'b0;
    end else if (push) begin
      idx  <= idx + 2'd1;
      rem  <= rem - thr;
      seen <= seen || (digit != 4'd0);
    end
  end

endmodule : cdfb_front
`default_nettype wire

// ===== rtl/cdfb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdfb_queue
// Small first-in first-out queue of frame descriptors.
// ----------------------------------------------------------------------------
module cdfb_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  cdfb_pkg::desc_t       push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output cdfb_pkg::desc_t       q_data
);
  import cdfb_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  desc_t       entries [QUEUE_DEPTH];
  logic [AW:0] wr_ptr;
  logic [AW:0] rd_ptr;

  assign q_valid = (wr_ptr != rd_ptr);
  assign full    = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign q_data  = entries[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + (AW+1)'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + (AW+1)'(1);
      end
    end
    if (push) begin
      entries[wr_ptr[AW-1:0]] <= push_data;
    end
  end

endmodule : cdfb_queue
`default_nettype wire

// ===== rtl/cdfb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdfb_back
// Expands each frame descriptor into one word per module, highest first.
// ----------------------------------------------------------------------------
module cdfb_back #(
  parameter int NUM_MODULES = cdfb_pkg::NUM_MODULES_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  cdfb_pkg::desc_t       q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            word_addr,
  output logic [7:0]            word_data,
  output logic                  end_of_frame,
  output logic                  last
);
  import cdfb_pkg::*;

  localparam int CNT_W = $clog2(NUM_MODULES + 1);

  desc_t            cur;
  logic             active;
  logic [CNT_W-1:0] cnt;
  logic             emit;
  logic             slot_one;
  logic             hit;

  assign slot_one = (cnt == CNT_W'(1));
  assign emit     = active && (!out_valid || out_ready);
  assign pop      = q_valid && (!active || (emit && slot_one));
  assign hit      = cur.all || (cur.target == 4'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (emit && slot_one) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    if (pop) begin
      cur <= q_data;
      cnt <= CNT_W'(NUM_MODULES);
    end else if (emit) begin
      cnt <= cnt - CNT_W'(1);
    end

    if (emit) begin
      word_addr    <= hit ? cur.addr : 4'd0;
      word_data    <= hit ? cur.data : 8'd0;
      end_of_frame <= slot_one;
      last         <= slot_one && cur.last;
    end
  end

endmodule : cdfb_back
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chained display frame builder.
// ----------------------------------------------------------------------------
// Every accepted request is expanded here into the words the chain should
// see: one frame per targeted write or broadcast, four frames per decimal
// write. The expanded words wait in order. Each word the block hands over is
// checked against the oldest waiting word. A short directed set comes
// first, then random requests under several idling mixes. One stretch holds
// the output side off long enough for the block to back up and stall its input.
// ----------------------------------------------------------------------------
module tb;
  import cdfb_pkg::*;

  localparam int NUM_MODULES = 4;
  localparam int HALF_PERIOD = 4;

  typedef struct {
    logic [3:0] addr;
    logic [7:0] data;
    logic       eof;
    logic       last;
  } chain_word_t;

  // Expands requests into chain words and compares the block's words against them.
  class chain_word_checker;
    chain_word_t words_due[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // One frame runs from module NUM_MODULES down to module 1.
    function void push_frame(bit all, logic [3:0] target, logic [3:0] addr,
                             logic [7:0] data);
      chain_word_t w;
      for (int m = NUM_MODULES; m >= 1; m--) begin
        if (all || m == target) begin
          w.addr = addr;
          w.data = data;
        end else begin
          w.addr = '0;
          w.data = '0;
        end
        w.eof  = (m == 1);
        w.last = 1'b0;
        words_due.push_back(w);
      end
    endfunction

    function void take_request(logic [1:0] kind, logic [3:0] mod, logic [3:0] addr,
                               logic [7:0] data, logic [15:0] val);
      logic [7:0] digit [4];
      int         rest;
      int         start;
      start = words_due.size();
      case (kind)
        REQ_TARGETED:  push_frame(1'b0, mod, addr, data);
        REQ_BROADCAST: push_frame(1'b1, '0, addr, data);
        REQ_DECIMAL: begin
          if (val > VALUE_MAX) begin
            for (int i = 0; i < 4; i++) digit[i] = CODE_DASH;
          end else begin
            rest = int'(val);
            digit[0] = 8'(rest / 1000);
            rest = rest % 1000;
            digit[1] = 8'(rest / 100);
            rest = rest % 100;
            digit[2] = 8'(rest / 10);
            digit[3] = 8'(rest % 10);
            // Leading zeros go blank; the ones digit always shows.
            for (int i = 0; i < 3; i++) begin
              if (digit[i] != 0) break;
              digit[i] = CODE_BLANK;
            end
          end
          for (int i = 0; i < 4; i++) push_frame(1'b0, mod, 4'(4 - i), digit[i]);
        end
        default: ;
      endcase
      if (words_due.size() > start) words_due[words_due.size() - 1].last = 1'b1;
    endfunction

    function void check_word(logic [3:0] addr, logic [7:0] data, logic eof,
                             logic last);
      chain_word_t w;
      if (words_due.size() == 0) begin
        $error("word with nothing expected: addr %0d data %0d", addr, data);
        errors++;
        return;
      end
      w = words_due.pop_front();
      if (addr !== w.addr) begin
        $error("word_addr: expected %0d, got %0d", w.addr, addr);
        errors++;
      end
      if (data !== w.data) begin
        $error("word_data: expected %0d, got %0d", w.data, data);
        errors++;
      end
      if (eof !== w.eof) begin
        $error("end_of_frame: expected %0d, got %0d", w.eof, eof);
        errors++;
      end
      if (last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [3:0]  module_req;
  logic [3:0]  reg_addr;
  logic [7:0]  reg_data;
  logic [15:0] value;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  word_addr;
  logic [7:0]  word_data;
  logic        end_of_frame;
  logic        last;

  // Idle mix. The sender's share is only read by the stimulus process, so it
  // is set with blocking assignments; the receiver's share and the hold-off
  // flag are read by the receiver process and are set with nonblocking ones.
  int send_idle_pct;
  int stall_pct;
  bit hold_off;

  chain_word_checker checker_h;

  chained_display_frame_builder_top #(.NUM_MODULES(NUM_MODULES)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .module_req(module_req),
    .reg_addr(reg_addr),
    .reg_data(reg_data),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .word_addr(word_addr),
    .word_data(word_data),
    .end_of_frame(end_of_frame),
    .last(last)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // The receiver decides at each falling edge whether it takes a word at the
  // next rising edge. During a hold-off it takes nothing at all.
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Both channels are sampled at the rising edge. Inputs only move at the
  // falling edge, so the values seen here are the ones the block registers.
  // A request's words cannot leave in the same cycle it is taken, but the
  // request is noted first regardless.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        checker_h.take_request(req_type, module_req, reg_addr, reg_data, value);
      end
      if (out_valid && out_ready) begin
        checker_h.check_word(word_addr, word_data, end_of_frame, last);
      end
    end
  end

  // Offers one request transaction, with random idle cycles ahead of it, and
  // returns at the falling edge after the block has taken it. The payload is
  // held steady the whole time valid is high.
  task automatic send_request(input logic [1:0] kind, input logic [3:0] mod,
                              input logic [3:0] addr, input logic [7:0] data,
                              input logic [15:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    module_req <= mod;
    reg_addr   <= addr;
    reg_data   <= data;
    value      <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random request. Most go to modules in range; decimal values cluster
  // around the blanking and the overflow boundaries as well as spanning the
  // full 16 bits. Reserved requests are sent but not counted.
  task automatic random_request(output bit counted);
    logic [1:0]  kind;
    logic [3:0]  mod;
    logic [15:0] val;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 30) kind = REQ_TARGETED;
    else if (pick < 50) kind = REQ_BROADCAST;
    else if (pick < 92) kind = REQ_DECIMAL;
    else kind = REQ_NONE;
    if ($urandom_range(9) < 8) mod = 4'($urandom_range(NUM_MODULES, 1));
    else mod = 4'($urandom_range(15, 0));
    case ($urandom_range(3))
      0: val = 16'($urandom_range(99));
      1: val = 16'($urandom_range(9999));
      2: val = 16'($urandom_range(10100, 9900));
      default: val = 16'($urandom_range(65535));
    endcase
    send_request(kind, mod, 4'($urandom_range(15)), 8'($urandom_range(255)), val);
    counted = (kind != REQ_NONE);
  endtask

  task automatic run_random(input int count, input int send_pct, input int recv_pct);
    int done;
    bit counted;
    done = 0;
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
    while (done < count) begin
      random_request(counted);
      if (counted) done++;
    end
  endtask

  // Blocks the output side, then opens it again.
  task automatic hold_receiver(input int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(negedge clk);
    hold_off <= 1'b0;
  endtask

  initial begin
    checker_h  = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_TARGETED;
    module_req = '0;
    reg_addr   = '0;
    reg_data   = '0;
    value      = '0;
    out_ready  = 1'b0;
    hold_off   = 1'b0;
    stall_pct  = 0;
    send_idle_pct = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: every slot, slots out of range, extreme bytes, both
    // ends of the digit range, leading-zero blanking, the overflow dashes,
    // and the reserved request type that must give no words.
    for (int m = 1; m <= NUM_MODULES; m++) begin
      send_request(REQ_TARGETED, 4'(m), 4'hF, 8'hFF, 16'hFFFF);
    end
    send_request(REQ_TARGETED, 4'd0, 4'hA, 8'h5A, 16'd0);
    send_request(REQ_TARGETED, 4'(NUM_MODULES + 1), 4'h3, 8'hA5, 16'd0);
    send_request(REQ_TARGETED, 4'd15, 4'h0, 8'h00, 16'd0);
    send_request(REQ_BROADCAST, 4'd0, 4'hF, 8'hFF, 16'hFFFF);
    send_request(REQ_BROADCAST, 4'd15, 4'h0, 8'h00, 16'd1234);
    send_request(REQ_DECIMAL, 4'd1, 4'hF, 8'hFF, 16'd0);
    send_request(REQ_DECIMAL, 4'(NUM_MODULES), 4'h0, 8'h00, 16'd7);
    send_request(REQ_DECIMAL, 4'd2, 4'h5, 8'h11, 16'd10);
    send_request(REQ_DECIMAL, 4'd3, 4'h5, 8'h11, 16'd100);
    send_request(REQ_DECIMAL, 4'd1, 4'h5, 8'h11, 16'd999);
    send_request(REQ_DECIMAL, 4'd2, 4'h5, 8'h11, 16'd1000);
    send_request(REQ_DECIMAL, 4'd3, 4'h5, 8'h11, 16'd9999);
    send_request(REQ_DECIMAL, 4'd4, 4'h5, 8'h11, 16'd10000);
    send_request(REQ_DECIMAL, 4'd1, 4'h5, 8'h11, 16'hFFFF);
    send_request(REQ_DECIMAL, 4'd0, 4'h5, 8'h11, 16'd5);
    send_request(REQ_NONE, 4'd1, 4'hF, 8'hFF, 16'd42);
    send_request(REQ_NONE, 4'd0, 4'h0, 8'h00, 16'hFFFF);

    // Random part under three idling mixes, starting with none at all.
    run_random(100, 0, 0);
    run_random(100, 50, 0);
    run_random(100, 0, 50);

    // Back-pressure stretch: the output side is shut for a long while as the
    // sender keeps pushing decimal writes, so the descriptor queue fills and
    // the block has to refuse input until the output side opens again.
    send_idle_pct = 0;
    stall_pct <= 0;
    fork
      hold_receiver(400);
      repeat (24) begin
        send_request(REQ_DECIMAL, 4'($urandom_range(NUM_MODULES, 1)),
                     4'($urandom_range(15)), 8'($urandom_range(255)),
                     16'($urandom_range(65535)));
      end
    join

    run_random(100, 15, 15);
    in_valid <= 1'b0;

    // Drain, then linger a while so that any stray extra word gets caught.
    while (checker_h.words_due.size() != 0) @(negedge clk);
    repeat (8 * NUM_MODULES) @(negedge clk);

    if (checker_h.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run of this stimulus.
  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
